// ===== sv/ckey_pkg.sv =====
// Shared types, constants and helper functions for the Caesar key search.
// Used by every module of the block; depends on nothing else.
package ckey_pkg;

  // Number of bytes kept behind the current one for word matching.
  localparam int unsigned HistDepth  = 4;
  localparam int unsigned WordTotal  = 6;
  localparam int unsigned WordMaxLen = 5;
  localparam int unsigned CountW     = 16;
  localparam int unsigned KeyW       = 5;
  localparam int unsigned ScoreW     = 17;
  localparam int unsigned PopW       = 3;
  localparam logic [7:0]  AlphaSize  = 8'd26;

  // Dictionary words, padded with zero bytes, and their lengths.
  localparam logic [7:0] WordChars [WordTotal][WordMaxLen] = '{
    '{"t", "h", "e", 8'h00, 8'h00},
    '{"a", "n", "d", 8'h00, 8'h00},
    '{"t", "h", "i", "s", 8'h00},
    '{"h", "e", "l", "l", "o"},
    '{"y", "o", "u", 8'h00, 8'h00},
    '{"q", "u", "e", "e", "n"}
  };
  localparam int unsigned WordLen [WordTotal] = '{3, 3, 4, 5, 3, 5};

  typedef logic [HistDepth-1:0][7:0] hist_t;
  typedef logic [WordTotal-1:0]      word_mask_t;

  // Partial result that travels down the scoring chain.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [KeyW-1:0]   best_key;
    logic [PopW-1:0]   best_pop;
  } sc_tok_t;

  // Final result word.
  typedef struct packed {
    logic [KeyW-1:0]   best_key;
    logic [ScoreW-1:0] best_score;
  } res_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= "A") && (b <= "Z");
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= "a") && (b <= "z");
  endfunction

  // Shift a letter back by key within the alphabet and fold it to lower case.
  function automatic logic [7:0] shift_back(input logic [7:0] b, input logic [KeyW-1:0] key);
    logic [5:0] idx;
    logic [5:0] t;
    idx = '0;
    if (is_upper(b)) begin
      idx = 6'(b - 8'h41);
    end else if (is_lower(b)) begin
      idx = 6'(b - 8'h61);
    end
    t = idx + 6'(AlphaSize) - {1'b0, key};
    if (t >= 6'(AlphaSize)) begin
      t = t - 6'(AlphaSize);
    end
    if (is_upper(b) || is_lower(b)) begin
      return 8'h61 + {2'b00, t};
    end
    return b;
  endfunction

  // Which dictionary words end at the current decrypted byte.
  function automatic word_mask_t word_hits(input logic [7:0] cur, input hist_t hist);
    word_mask_t hits;
    logic       hit;
    logic [7:0] src;
    hits = '0;
    for (int w = 0; w < WordTotal; w++) begin
      hit = 1'b1;
      for (int p = 0; p < WordMaxLen; p++) begin
        if (p < WordLen[w]) begin
          if (p == WordLen[w] - 1) begin
            src = cur;
          end else begin
            src = hist[2'(WordLen[w] - 2 - p)];
          end
          if (src != WordChars[w][p]) begin
            hit = 1'b0;
          end
        end
      end
      hits[w] = hit;
    end
    return hits;
  endfunction

endpackage

// ===== sv/ckey_lane.sv =====
// One key lane: decrypts the byte stream under a fixed key and records found words.
// Depends on ckey_pkg.
module ckey_lane #(
  parameter int unsigned KEY = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               byte_i,
  input  logic                     last_i,
  output logic [ckey_pkg::PopW-1:0] pop_o
);
  import ckey_pkg::*;

  hist_t      dec_hist_q, dec_hist_d;
  word_mask_t found_q, found_d;
  logic [7:0] dec_cur;
  word_mask_t found_all;

  // Decrypt the incoming byte and match words against the decrypted history.
  always_comb begin
    dec_cur   = shift_back(byte_i, KeyW'(KEY));
    found_all = found_q | word_hits(dec_cur, dec_hist_q);
    pop_o     = PopW'($countones(found_all));
  end

  // The lane state clears after the last byte of a message.
  always_comb begin
    dec_hist_d = dec_hist_q;
    found_d    = found_q;
    if (accept_i) begin
      if (last_i) begin
        dec_hist_d = '0;
        found_d    = '0;
      end else begin
        dec_hist_d = {dec_hist_q[HistDepth-2:0], dec_cur};
        found_d    = found_all;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_hist_q <= '0;
      found_q    <= '0;
    end else begin
      dec_hist_q <= dec_hist_d;
      found_q    <= found_d;
    end
  end

endmodule

// ===== sv/ckey_score_cell.sv =====
// One stage of the scoring chain: compares one key's word count with the best so far.
// Depends on ckey_pkg.
module ckey_score_cell #(
  parameter int unsigned KEY_COUNT = 25,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  ckey_pkg::sc_tok_t                        tok_i,
  input  logic [KEY_COUNT-1:0][ckey_pkg::PopW-1:0] pops_i,
  output logic                                     valid_o,
  output ckey_pkg::sc_tok_t                        tok_o,
  output logic [KEY_COUNT-1:0][ckey_pkg::PopW-1:0] pops_o
);
  import ckey_pkg::*;

  logic                           valid_q;
  sc_tok_t                        tok_q, tok_d;
  logic [KEY_COUNT-1:0][PopW-1:0] pops_q;

  // A strictly greater count takes over, so ties keep the lower key.
  always_comb begin
    tok_d = tok_i;
    if (pops_i[CELL_IDX] > tok_i.best_pop) begin
      tok_d.best_pop = pops_i[CELL_IDX];
      tok_d.best_key = KeyW'(CELL_IDX + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    pops_q <= pops_i;
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
  assign pops_o  = pops_q;

endmodule

// ===== sv/ckey_fifo.sv =====
// Result queue with a registered output word in front of the receiver.
// Depends on ckey_pkg.
module ckey_fifo #(
  parameter int unsigned DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ckey_pkg::res_t push_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ckey_pkg::res_t out_data_o
);
  import ckey_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  res_t             out_q;
  logic             out_vld_q, out_vld_d;
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  // Refill the output word whenever it is empty or being taken.
  assign pop = (cnt_q != '0) && (!out_vld_q || out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AddrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + AddrW'(1);
      end
    end
  end

  // Storage array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
    if (pop) begin
      out_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(DEPTH)) || pop)
    else $error("result queue written while full");

  fifo_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_vld_q)
    else $error("output word not loaded after a queue read");

  fifo_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not follow a write");

endmodule

// ===== sv/caesar_key_search.sv =====
// Caesar key search top level: key lanes, scoring chain and result queue.
// Depends on ckey_pkg, ckey_lane, ckey_score_cell and ckey_fifo.
//
// Usage: ciphertext arrives one byte per word on the input channel
// (cipher_byte_i, last_i). Every key 1..KEY_COUNT has its own lane that
// decrypts the byte and updates which dictionary words it has seen. The word
// that carries last_i = 1 closes the message: its per-key word counts enter a
// chain of KEY_COUNT scoring cells, one key per cell, and the winner (lowest
// key on ties) leaves on the output channel as best_key_o and best_score_o.
// All message state clears on that word, so the next message may follow at
// once. One input word is accepted every cycle while in_ready_o is high. A
// result passes the scoring cells in order, the first loading at the
// accepting edge, then the queue write and the output register. Results
// wait in a queue when the receiver stalls; input stays open until the
// number of messages in flight or waiting equals the queue depth, which is
// chosen to cover the chain latency. Reset empties the chain and the queue
// and clears every lane and the letter count.
module caesar_key_search #(
  parameter int unsigned KEY_COUNT = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    cipher_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ckey_pkg::KeyW-1:0]     best_key_o,
  output logic [ckey_pkg::ScoreW-1:0]   best_score_o
);
  import ckey_pkg::*;

  localparam int unsigned FifoDepth = 2 ** $clog2(KEY_COUNT + 4);
  localparam int unsigned OutW      = $clog2(FifoDepth + 1);

  logic                           in_fire, out_fire;
  logic [KEY_COUNT-1:0][PopW-1:0] lane_pop;
  logic [CountW-1:0]              count_q, count_d;
  logic                           is_ls;
  logic [OutW-1:0]                outst_q, outst_d;

  logic                           vld_c  [KEY_COUNT+1];
  sc_tok_t                        tok_c  [KEY_COUNT+1];
  logic [KEY_COUNT-1:0][PopW-1:0] pops_c [KEY_COUNT+1];

  sc_tok_t                        tail;
  res_t                           push_data;
  res_t                           out_data;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign in_ready_o = (outst_q != OutW'(FifoDepth));

  // Key lanes, one per candidate key.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    ckey_lane #(
      .KEY (k + 1)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (in_fire),
      .byte_i   (cipher_byte_i),
      .last_i   (last_i),
      .pop_o    (lane_pop[k])
    );
  end

  // Saturating count of letters and spaces, shared by all keys.
  always_comb begin
    is_ls   = is_upper(cipher_byte_i) || is_lower(cipher_byte_i) || (cipher_byte_i == " ");
    count_d = count_q;
    if (is_ls && (count_q != '1)) begin
      count_d = count_q + CountW'(1);
    end
  end

  // Messages in flight or waiting; limits intake to the queue depth.
  always_comb begin
    outst_d = outst_q;
    if ((in_fire && last_i) && !out_fire) begin
      outst_d = outst_q + OutW'(1);
    end else if (out_fire && !(in_fire && last_i)) begin
      outst_d = outst_q - OutW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
      if (in_fire) begin
        count_q <= last_i ? '0 : count_d;
      end
    end
  end

  // Head of the scoring chain: key 1 with zero words is the starting best.
  assign vld_c[0]  = in_fire && last_i;
  assign tok_c[0]  = '{count: count_d, best_key: KeyW'(1), best_pop: '0};
  assign pops_c[0] = lane_pop;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_cell
    ckey_score_cell #(
      .KEY_COUNT (KEY_COUNT),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[k]),
      .tok_i   (tok_c[k]),
      .pops_i  (pops_c[k]),
      .valid_o (vld_c[k+1]),
      .tok_o   (tok_c[k+1]),
      .pops_o  (pops_c[k+1])
    );
  end

  // Final score: ten points per word plus the letter and space count.
  always_comb begin
    tail                 = tok_c[KEY_COUNT];
    push_data.best_key   = tail.best_key;
    push_data.best_score = ScoreW'(tail.count)
                         + (ScoreW'(tail.best_pop) << 3)
                         + (ScoreW'(tail.best_pop) << 1);
  end

  ckey_fifo #(
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (vld_c[KEY_COUNT]),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign best_key_o   = out_data.best_key;
  assign best_score_o = out_data.best_score;

  key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_key_o >= KeyW'(1)) && (best_key_o <= KeyW'(KEY_COUNT)))
    else $error("result key outside the candidate range");

  result_has_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != '0)
    else $error("result shown with no message outstanding");

  chain_needs_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[KEY_COUNT] |-> outst_q != '0)
    else $error("scoring chain produced a result with no message outstanding");

endmodule

// ===== tb/sv/caesar_key_search_test.sv =====
// Self-checking testbench for the Caesar key search block.
// Drives ciphertext messages through the input channel and checks every key and score
// against a local scorer; depends on ckey_pkg and caesar_key_search.
module caesar_key_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyCount   = 25;
  localparam int unsigned WordPoints = 10;
  localparam int unsigned ScoreBits  = ckey_pkg::ScoreW;
  localparam int unsigned DrainCyc   = KeyCount + 2 + 16;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned RandTarget = 850;
  localparam int unsigned QuietFirst = 200;
  localparam int unsigned QuietLast  = 800;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [7:0]                  cipher_byte_i;
  logic                        last_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [ckey_pkg::KeyW-1:0]   best_key_o;
  logic [ckey_pkg::ScoreW-1:0] best_score_o;

  // Stimulus waiting for the driver and key results waiting for the output.
  cipher_word_t     pending_bytes[$];
  ckey_pkg::res_t   expected_results[$];

  // Scorer state: raw byte history, words seen per key, letter-and-space count.
  logic [7:0]       hist_q[ckey_pkg::HistDepth];
  logic [5:0]       seen_words[KeyCount];
  logic [15:0]      letter_count;

  string            dict_word[6] = '{"the", "and", "this", "hello", "you", "queen"};

  int unsigned      cycle_cnt;
  int unsigned      fail_count;
  int unsigned      results_checked;
  int unsigned      bytes_scored;

  caesar_key_search #(
    .KEY_COUNT(KeyCount)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cipher_byte_i(cipher_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_key_o   (best_key_o),
    .best_score_o (best_score_o)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Decrypt one raw byte under a key and fold letters to lower case.
  function automatic logic [7:0] undo_shift(input logic [7:0] b, input int shift);
    int idx;
    if (b >= "A" && b <= "Z") begin
      idx = b - "A";
    end else if (b >= "a" && b <= "z") begin
      idx = b - "a";
    end else begin
      return b;
    end
    return 8'("a" + (idx + 26 - shift) % 26);
  endfunction

  // Encrypt one plaintext lower-case letter, optionally in upper case.
  function automatic logic [7:0] shift_fwd(input byte c, input int shift, input bit upcase);
    int idx;
    if (c < "a" || c > "z") begin
      return 8'(c);
    end
    idx = (c - "a" + shift) % 26;
    return upcase ? 8'("A" + idx) : 8'("a" + idx);
  endfunction

  task automatic clear_scorer();
    foreach (hist_q[i]) hist_q[i] = '0;
    foreach (seen_words[k]) seen_words[k] = '0;
    letter_count = '0;
  endtask

  // Update word matches and the count with one accepted byte, and score the
  // message when the byte closes it.
  task automatic absorb_byte(input logic [7:0] cur, input logic closes);
    int                          len;
    logic                        hit;
    logic [7:0]                  src;
    logic [ckey_pkg::ScoreW-1:0] score;
    ckey_pkg::res_t              top;
    for (int k = 0; k < KeyCount; k++) begin
      for (int w = 0; w < 6; w++) begin
        len = dict_word[w].len();
        hit = 1'b1;
        for (int p = 0; p < len; p++) begin
          src = (p == len - 1) ? cur : hist_q[len - 2 - p];
          if (undo_shift(src, k + 1) != 8'(dict_word[w][p])) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          seen_words[k][w] = 1'b1;
        end
      end
    end
    if (((cur >= "a" && cur <= "z") || (cur >= "A" && cur <= "Z") || cur == " ")
        && letter_count != 16'hFFFF) begin
      letter_count++;
    end
    for (int i = ckey_pkg::HistDepth - 1; i > 0; i--) begin
      hist_q[i] = hist_q[i - 1];
    end
    hist_q[0] = cur;
    bytes_scored++;
    if (closes) begin
      top = '0;
      for (int k = 0; k < KeyCount; k++) begin
        score = ScoreBits'(letter_count)
              + ScoreBits'(WordPoints * $countones(seen_words[k]));
        if (k == 0 || score > top.best_score) begin
          top.best_key   = 5'(k + 1);
          top.best_score = score;
        end
      end
      expected_results.push_back(top);
      clear_scorer();
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    cipher_word_t cw;
    cw.data = b;
    cw.last = 1'b0;
    pending_bytes.push_back(cw);
  endtask

  // Encrypt a plaintext string under a key; letters turn upper case at the given odds.
  task automatic queue_text(input string plain, input int shift, input int upper_pct);
    for (int i = 0; i < plain.len(); i++) begin
      push_byte(shift_fwd(plain[i], shift, $urandom_range(99, 0) < upper_pct));
    end
  endtask

  task automatic end_message();
    pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic bit quiet_now();
    return cycle_cnt >= QuietFirst && cycle_cnt < QuietLast;
  endfunction

  // Input driver: a new word is offered only once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      cipher_byte_i <= '0;
      last_i        <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_bytes.size() > 0 && (quiet_now() || $urandom_range(99, 0) >= 10)) begin
        in_valid_i    <= 1'b1;
        cipher_byte_i <= pending_bytes[0].data;
        last_i        <= pending_bytes[0].last;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls at random outside the quiet stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_now() || $urandom_range(99, 0) >= 10;
    end
  end

  // Monitor: score accepted input words, check result words, watch the limit.
  always @(posedge clk_i) begin
    ckey_pkg::res_t want;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        if (in_valid_i && in_ready_o) begin
          absorb_byte(cipher_byte_i, last_i);
        end
        if (out_valid_o && out_ready_i) begin
          if (expected_results.size() == 0) begin
            report($sformatf("result key %0d score %0d with none pending",
                             best_key_o, best_score_o));
          end else begin
            want = expected_results.pop_front();
            if (best_key_o !== want.best_key) begin
              report($sformatf("best_key expected %0d got %0d", want.best_key, best_key_o));
            end
            if (best_score_o !== want.best_score) begin
              report($sformatf("best_score expected %0d got %0d",
                               want.best_score, best_score_o));
            end
            results_checked++;
          end
        end
      end
    end
  end

  // Build all messages, release reset, then wait for the last result.
  initial begin
    int unsigned rand_bytes;
    int unsigned start;
    int          shift;
    int          upper_pct;
    int          sel;
    string       piece;
    rst_ni           = 1'b0;
    cycle_cnt        = 0;
    fail_count       = 0;
    results_checked  = 0;
    bytes_scored     = 0;
    rand_bytes       = 0;
    clear_scorer();

    // Directed: the bytes 8'h01 and 8'hFF alone, mixed case, zero and high
    // bytes, a tie between two keys, and a word cut across two messages.
    push_byte(8'h01);
    end_message();
    push_byte(8'hFF);
    end_message();
    queue_text("hello", 3, 50);
    end_message();
    push_byte("A");
    push_byte(8'h00);
    push_byte("Z");
    push_byte("z");
    push_byte(" ");
    push_byte(8'h80);
    end_message();
    queue_text("the", 5, 0);
    push_byte(" ");
    queue_text("and", 2, 100);
    end_message();
    queue_text("th", 3, 0);
    end_message();
    queue_text("e", 3, 0);
    end_message();

    // Random messages: mostly encrypted words with random content, some noise.
    while (rand_bytes < RandTarget) begin
      start = pending_bytes.size();
      if ($urandom_range(99, 0) < 15) begin
        repeat ($urandom_range(12, 1)) push_byte(8'($urandom_range(255, 1)));
      end else begin
        shift     = $urandom_range(25, 0);
        upper_pct = $urandom_range(3, 0) * 30;
        repeat ($urandom_range(6, 1)) begin
          sel = $urandom_range(99, 0);
          if (sel < 55) begin
            piece = dict_word[$urandom_range(5, 0)];
            if ($urandom_range(99, 0) < 15) begin
              piece = piece.substr(0, piece.len() - 2);
            end
            queue_text(piece, shift, upper_pct);
          end else if (sel < 80) begin
            repeat ($urandom_range(6, 1)) begin
              push_byte(shift_fwd(byte'("a" + $urandom_range(25, 0)), shift,
                                  $urandom_range(99, 0) < upper_pct));
            end
          end else if (sel < 90) begin
            push_byte(8'($urandom_range(255, 1)));
          end else begin
            push_byte(8'($urandom_range(64, 33)));
          end
          if ($urandom_range(99, 0) < 85) begin
            push_byte(" ");
          end
        end
      end
      end_message();
      rand_bytes += pending_bytes.size() - start;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_bytes.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (expected_results.size() == 0);
    repeat (DrainCyc) @(posedge clk_i);

    $display("Scored %0d messages over %0d ciphertext bytes, with mixed case, stray bytes,",
             results_checked, bytes_scored);
    $display("key ties and split words; %0d mismatches seen.", fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ckey_pkg.sv
sv/ckey_lane.sv
sv/ckey_score_cell.sv
sv/ckey_fifo.sv
sv/caesar_key_search.sv
tb/sv/caesar_key_search_test.sv
